[hw/rtl/srrip_pkg.sv]
// Shared constants, types and codes for the SRRIP set replacement block.
`default_nettype none
package srrip_pkg;

  // Default parameter values
  localparam int WAYS_DEF      = 16;
  localparam int RRPV_BITS_DEF = 2;
  localparam int TAG_BITS_DEF  = 32;

  // Fixed channel field widths
  localparam int IN_TAG_W  = 32;
  localparam int OUT_WAY_W = 4;
  localparam int OUT_TAG_W = 32;

  // Configuration register file
  localparam int WIU_W      = 5;
  localparam int INS_W      = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [WIU_W-1:0] WIU_RESET = 5'd16;
  localparam logic [INS_W-1:0] INS_RESET = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_WAYS_IN_USE = 1'b0;
  localparam logic REG_INSERT_RRPV = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } ctl_state_t;

  // Search flags that ride along the cell chain with each beat
  typedef struct packed {
    logic vld;
    logic hit_found;
    logic inv_found;
  } srch_flags_t;

endpackage
`default_nettype wire

[hw/rtl/srrip_if.sv]
// Valid/ready channel interfaces for the access and result beats.
`default_nettype none
interface srrip_in_if import srrip_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IN_TAG_W-1:0] tag;

  modport source (output valid, output tag, input ready);
  modport sink   (input valid, input tag, output ready);
endinterface

interface srrip_out_if import srrip_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [OUT_WAY_W-1:0] way_num;
  logic                 evicted;
  logic [OUT_TAG_W-1:0] evicted_tag;

  modport source (output valid, output hit, output way_num, output evicted,
                  output evicted_tag, input ready);
  modport sink   (input valid, input hit, input way_num, input evicted,
                  input evicted_tag, output ready);
endinterface
`default_nettype wire

[hw/rtl/srrip_cache_set_replacement.sv]
// Top level: SRRIP replacement for one cache set as a chain of way cells.
// The result beat passes the cell chain, the pending register and the output register.
// The block takes one access at a time: a new access is taken only after the last
//   result is loaded into the output register, which can wait on out_ch.ready.
// Reset (sync, active low): all ways invalid, RRPVs 0, ways_in_use 16,
//   insert_rrpv 2. Line tags are not reset; no clearing pass is needed.
`default_nettype none
module srrip_cache_set_replacement import srrip_pkg::*; #(
  parameter int WAYS      = WAYS_DEF,
  parameter int RRPV_BITS = RRPV_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  srrip_in_if.sink                   in_ch,
  srrip_out_if.source                out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]     act_ways;
  logic [RRPV_BITS-1:0] ins_rrpv;

  srrip_cfg #(
    .WAYS      (WAYS),
    .RRPV_BITS (RRPV_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .act_ways (act_ways),
    .ins_rrpv (ins_rrpv)
  );

  // ---------------------------------------------------------------------------
  // Search chain. Stage 0 is the incoming beat; stage i+1 is the register
  // output of cell i. Each cell folds in hit match, first empty way and the
  // running max-RRPV victim (strict > keeps the lowest index on ties).
  // ---------------------------------------------------------------------------
  srch_flags_t          st_flg       [WAYS+1];
  logic [TAG_BITS-1:0]  st_tag       [WAYS+1];
  logic [WAY_W-1:0]     st_hit_way   [WAYS+1];
  logic [WAY_W-1:0]     st_inv_way   [WAYS+1];
  logic [RRPV_BITS-1:0] st_best_rrpv [WAYS+1];
  logic [WAY_W-1:0]     st_best_way  [WAYS+1];
  logic [TAG_BITS-1:0]  st_best_tag  [WAYS+1];
  logic [WAYS-1:0]      chain_vld;

  logic [TAG_BITS+IN_TAG_W-1:0] tag_ext;
  logic                         in_acc;

  // wr_* broadcast the decision to all cells at chain end
  logic                 wr_en;
  logic [WAY_W-1:0]     wr_way;
  logic [RRPV_BITS-1:0] wr_rrpv;

  assign in_acc  = in_ch.valid && in_ch.ready;
  // keep only TAG_BITS of the access tag
  assign tag_ext = {{TAG_BITS{1'b0}}, in_ch.tag};

  always_comb begin
    st_flg[0].vld       = in_acc;
    st_flg[0].hit_found = 1'b0;
    st_flg[0].inv_found = 1'b0;
    st_tag[0]           = tag_ext[TAG_BITS-1:0];
    st_hit_way[0]       = '0;
    st_inv_way[0]       = '0;
    st_best_rrpv[0]     = '0;
    st_best_way[0]      = '0;
    st_best_tag[0]      = '0;
  end

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    srrip_cell #(
      .WAYS      (WAYS),
      .RRPV_BITS (RRPV_BITS),
      .TAG_BITS  (TAG_BITS),
      .IDX       (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .act_ways    (act_ways),
      .flg_i       (st_flg[i]),
      .tag_i       (st_tag[i]),
      .hit_way_i   (st_hit_way[i]),
      .inv_way_i   (st_inv_way[i]),
      .best_rrpv_i (st_best_rrpv[i]),
      .best_way_i  (st_best_way[i]),
      .best_tag_i  (st_best_tag[i]),
      .flg_o       (st_flg[i+1]),
      .tag_o       (st_tag[i+1]),
      .hit_way_o   (st_hit_way[i+1]),
      .inv_way_o   (st_inv_way[i+1]),
      .best_rrpv_o (st_best_rrpv[i+1]),
      .best_way_o  (st_best_way[i+1]),
      .best_tag_o  (st_best_tag[i+1]),
      .wr_en       (wr_en),
      .wr_way      (wr_way),
      .wr_tag      (st_tag[WAYS]),
      .wr_rrpv     (wr_rrpv)
    );
    assign chain_vld[i] = st_flg[i+1].vld;
  end

  // ---------------------------------------------------------------------------
  // Decision at chain end: hit, else first empty way, else max-RRPV victim.
  // ---------------------------------------------------------------------------
  srch_flags_t fin;
  logic        fin_evict;

  assign fin = st_flg[WAYS];

  always_comb begin
    fin_evict = 1'b0;
    if (fin.hit_found) begin
      wr_way = st_hit_way[WAYS];
    end else if (fin.inv_found) begin
      wr_way = st_inv_way[WAYS];
    end else begin
      wr_way    = st_best_way[WAYS];
      fin_evict = 1'b1;
    end
    wr_rrpv = fin.hit_found ? '0 : ins_rrpv;
  end

  // ---------------------------------------------------------------------------
  // Control: IDLE takes an access, SWEEP waits for chain end (and commits the
  // line update), HOLD moves the decision into the output register.
  // ---------------------------------------------------------------------------
  ctl_state_t state_r, state_nxt;
  logic       pend_ld;
  logic       out_ld;
  logic       out_valid_r, out_valid_nxt;

  logic                 pend_hit_r;
  logic [WAY_W-1:0]     pend_way_r;
  logic                 pend_evict_r;
  logic [TAG_BITS-1:0]  pend_evtag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    pend_ld     = 1'b0;
    out_ld      = 1'b0;
    wr_en       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (fin.vld) begin
          pend_ld   = 1'b1;
          wr_en     = 1'b1;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_ld    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pend_ld) begin
      pend_hit_r   <= fin.hit_found;
      pend_way_r   <= wr_way;
      pend_evict_r <= fin_evict;
      pend_evtag_r <= fin_evict ? st_best_tag[WAYS] : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [WAY_W+OUT_WAY_W-1:0]    way_ext;
  logic [TAG_BITS+OUT_TAG_W-1:0] evtag_ext;
  logic                          out_hit_r;
  logic [OUT_WAY_W-1:0]          out_way_r;
  logic                          out_evict_r;
  logic [OUT_TAG_W-1:0]          out_evtag_r;

  assign way_ext   = {{OUT_WAY_W{1'b0}}, pend_way_r};
  assign evtag_ext = {{OUT_TAG_W{1'b0}}, pend_evtag_r};

  always_comb begin
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_hit_r   <= pend_hit_r;
      out_way_r   <= way_ext[OUT_WAY_W-1:0];
      out_evict_r <= pend_evict_r;
      out_evtag_r <= evtag_ext[OUT_TAG_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.way_num     = out_way_r;
  assign out_ch.evicted     = out_evict_r;
  assign out_ch.evicted_tag = out_evtag_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Only one access travels the chain at a time.
  a_one_beat_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one beat in the cell chain");

  // The chain only carries a beat while the controller is sweeping.
  a_chain_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_vld != '0) |-> (state_r == ST_SWEEP))
    else $error("chain beat outside sweep");

  // An accepted access reaches the chain end after passing every cell register.
  a_chain_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##WAYS fin.vld)
    else $error("chain latency mismatch");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.hit) |-> (!out_ch.evicted && (out_ch.evicted_tag == '0)))
    else $error("hit result carries an eviction");

endmodule
`default_nettype wire

[hw/rtl/srrip_cell.sv]
// One way of the set: line state plus one stage of the search chain.
`default_nettype none
module srrip_cell import srrip_pkg::*; #(
  parameter int WAYS      = WAYS_DEF,
  parameter int RRPV_BITS = RRPV_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF,
  parameter int IDX       = 0,
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int CNT_W    = $clog2(WAYS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [CNT_W-1:0]     act_ways,
  // search beat from the previous cell
  input  wire srch_flags_t          flg_i,
  input  wire logic [TAG_BITS-1:0]  tag_i,
  input  wire logic [WAY_W-1:0]     hit_way_i,
  input  wire logic [WAY_W-1:0]     inv_way_i,
  input  wire logic [RRPV_BITS-1:0] best_rrpv_i,
  input  wire logic [WAY_W-1:0]     best_way_i,
  input  wire logic [TAG_BITS-1:0]  best_tag_i,
  // search beat to the next cell
  output      srch_flags_t          flg_o,
  output      logic [TAG_BITS-1:0]  tag_o,
  output      logic [WAY_W-1:0]     hit_way_o,
  output      logic [WAY_W-1:0]     inv_way_o,
  output      logic [RRPV_BITS-1:0] best_rrpv_o,
  output      logic [WAY_W-1:0]     best_way_o,
  output      logic [TAG_BITS-1:0]  best_tag_o,
  // line update
  input  wire logic                 wr_en,
  input  wire logic [WAY_W-1:0]     wr_way,
  input  wire logic [TAG_BITS-1:0]  wr_tag,
  input  wire logic [RRPV_BITS-1:0] wr_rrpv
);

  localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(IDX);
  localparam logic [WAY_W-1:0] IDX_WAY = WAY_W'(IDX);

  logic                 valid_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic [RRPV_BITS-1:0] rrpv_r;

  logic act, hit_here, inv_here, take_best;

  always_comb begin
    act       = IDX_CNT < act_ways;
    hit_here  = act && valid_r && (tag_r == tag_i) && !flg_i.hit_found;
    inv_here  = act && !valid_r && !flg_i.inv_found;
    // way 0 seeds the victim search
    take_best = act && ((IDX == 0) || (rrpv_r > best_rrpv_i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rrpv_r  <= '0;
    end else if (wr_en && (wr_way == IDX_WAY)) begin
      valid_r <= 1'b1;
      rrpv_r  <= wr_rrpv;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_way == IDX_WAY)) begin
      tag_r <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_o <= '0;
    end else begin
      flg_o.vld       <= flg_i.vld;
      flg_o.hit_found <= flg_i.hit_found || hit_here;
      flg_o.inv_found <= flg_i.inv_found || inv_here;
    end
  end

  always_ff @(posedge clk) begin
    tag_o       <= tag_i;
    hit_way_o   <= hit_here  ? IDX_WAY : hit_way_i;
    inv_way_o   <= inv_here  ? IDX_WAY : inv_way_i;
    best_rrpv_o <= take_best ? rrpv_r  : best_rrpv_i;
    best_way_o  <= take_best ? IDX_WAY : best_way_i;
    best_tag_o  <= take_best ? tag_r   : best_tag_i;
  end

endmodule
`default_nettype wire

[hw/rtl/srrip_cfg.sv]
// APB register file: ways in use and insertion RRPV, with range clamping.
`default_nettype none
module srrip_cfg import srrip_pkg::*; #(
  parameter int WAYS      = WAYS_DEF,
  parameter int RRPV_BITS = RRPV_BITS_DEF,
  localparam int CNT_W    = $clog2(WAYS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready,
  output      logic [CNT_W-1:0]      act_ways,
  output      logic [RRPV_BITS-1:0]  ins_rrpv
);

  localparam int AW = CNT_W + WIU_W;
  localparam int RW = RRPV_BITS + INS_W;
  localparam logic [AW-1:0] WAYS_X     = AW'(WAYS);
  localparam logic [AW-1:0] ONE_X      = AW'(1);
  localparam logic [RW-1:0] RRPV_MAX_X = RW'((1 << RRPV_BITS) - 1);

  logic [WIU_W-1:0] wiu_r;
  logic [INS_W-1:0] ins_r;
  logic             wr;
  logic             reg_sel;
  logic [AW-1:0]    wiu_x;
  logic [AW-1:0]    act_x;
  logic [RW-1:0]    ins_x;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  // byte offset bits are ignored
  assign reg_sel = paddr[CFG_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wiu_r <= WIU_RESET;
      ins_r <= INS_RESET;
    end else if (wr) begin
      if (reg_sel == REG_WAYS_IN_USE) begin
        wiu_r <= pwdata[WIU_W-1:0];
      end else begin
        ins_r <= pwdata[INS_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_WAYS_IN_USE) begin
      prdata = CFG_DATA_W'(wiu_r);
    end else begin
      prdata = CFG_DATA_W'(ins_r);
    end
  end

  // zero acts as one, above WAYS acts as WAYS
  always_comb begin
    wiu_x = {{CNT_W{1'b0}}, wiu_r};
    if (wiu_x == '0) begin
      act_x = ONE_X;
    end else if (wiu_x > WAYS_X) begin
      act_x = WAYS_X;
    end else begin
      act_x = wiu_x;
    end
    act_ways = act_x[CNT_W-1:0];
  end

  // saturate to the RRPV range
  always_comb begin
    ins_x = {{RRPV_BITS{1'b0}}, ins_r};
    if (ins_x > RRPV_MAX_X) begin
      ins_rrpv = RRPV_MAX_X[RRPV_BITS-1:0];
    end else begin
      ins_rrpv = ins_x[RRPV_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

[bench/tb_srrip_cache_set_replacement.sv]
// Testbench for the SRRIP set replacement block: directed table, random accesses, self-check.
module tb_srrip_cache_set_replacement import srrip_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Expected/observed result beat, packed so a whole beat moves as one value
  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic                 evicted;
    logic [OUT_TAG_W-1:0] ev_tag;
  } set_result_t;

  // Directed table: register writes, accesses checked against a typed-in
  // result, and accesses checked against the set model below
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_ACCESS_TYPED,
    ROW_ACCESS
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic            reg_idx;
    logic [31:0]     data;     // tag for accesses, register value for writes
    set_result_t     want;
  } stim_row_t;

  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ACCESSES  = 50;
  localparam int HOT_TAGS        = 24;
  localparam int LONG_HOLD_AT    = 200;  // results seen before the long stall
  localparam int LONG_HOLD_LEN   = 400;  // cycles the result side holds off
  localparam int SETTLE_CYCLES   = WAYS_DEF + 4;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  srrip_in_if  in_ch ();
  srrip_out_if out_ch ();

  srrip_cache_set_replacement u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Set model: tags, valid bits and RRPVs of all ways plus the two registers.
  // Ways past ways_in_use keep whatever they held.
  // ---------------------------------------------------------------------------
  logic                     way_valid [WAYS_DEF];
  logic [IN_TAG_W-1:0]      way_tag   [WAYS_DEF];
  logic [RRPV_BITS_DEF-1:0] way_rrpv  [WAYS_DEF];
  logic [WIU_W-1:0]         cfg_ways_in_use;
  logic [INS_W-1:0]         cfg_insert_rrpv;

  set_result_t pending_results [$];   // one per accepted access, oldest first
  int          fail_count   = 0;
  int          results_seen = 0;
  bit          tx_steady    = 1'b0;   // sender offers back to back
  bit          rx_steady    = 1'b0;   // result side always ready

  // 0 behaves as one way, anything past the way count as all ways
  function automatic int active_ways();
    if (cfg_ways_in_use == '0) return 1;
    if (cfg_ways_in_use > WAYS_DEF) return WAYS_DEF;
    return int'(cfg_ways_in_use);
  endfunction

  function automatic set_result_t predict_access(input logic [IN_TAG_W-1:0] t);
    set_result_t              r;
    int                       n;
    int                       w;
    bit                       found;
    logic [RRPV_BITS_DEF-1:0] best;
    n     = active_ways();
    r     = '0;
    w     = 0;
    found = 1'b0;
    // hit: lowest valid way in use that holds the tag
    for (int i = 0; i < n; i++) begin
      if (!found && way_valid[i] && way_tag[i] == t) begin
        found = 1'b1;
        w     = i;
      end
    end
    if (found) begin
      r.hit       = 1'b1;
      way_rrpv[w] = '0;
    end else begin
      // miss: lowest empty way first
      for (int i = 0; i < n; i++) begin
        if (!found && !way_valid[i]) begin
          found = 1'b1;
          w     = i;
        end
      end
      // set full: lowest way with the largest RRPV present, no aging
      if (!found) begin
        best = '0;
        w    = 0;
        for (int i = 0; i < n; i++) begin
          if (way_rrpv[i] > best) begin
            best = way_rrpv[i];
            w    = i;
          end
        end
        r.evicted = 1'b1;
        r.ev_tag  = way_tag[w];
      end
      way_valid[w] = 1'b1;
      way_tag[w]   = t;
      way_rrpv[w]  = cfg_insert_rrpv;
    end
    r.way = w[OUT_WAY_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Table row builders
  // ---------------------------------------------------------------------------
  function automatic stim_row_t reg_row(input logic idx, input logic [31:0] value);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.data    = value;
    return row;
  endfunction

  function automatic stim_row_t model_row(input logic [31:0] t);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_ACCESS;
    row.data = t;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [31:0] t, input logic hit,
                                          input logic [3:0] way, input logic ev,
                                          input logic [31:0] ev_tag);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_ACCESS_TYPED;
    row.data = t;
    row.want = '{hit: hit, way: way, evicted: ev, ev_tag: ev_tag};
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks. All of them start and end on a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one access beat; the expectation is queued at the accepting edge.
  // valid is left high so a back-to-back beat needs no second assignment.
  task automatic send_access(input logic [IN_TAG_W-1:0] t, input bit typed,
                             input set_result_t want);
    set_result_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.tag   <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_access(t);
    if (typed) predicted = want;
    pending_results = {pending_results, predicted};
  endtask

  // Random gap ahead of an access: mostly none or short, now and then long
  task automatic pace_sender();
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!tx_steady) begin
      if (r >= 90)      gap = $urandom_range(25, 80);
      else if (r >= 50) gap = $urandom_range(1, 20);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result, plus slack for the
  // cell chain to go quiet before a register write
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then an idle phase with psel low so back-to-back
  // writes never assign psel twice in one step
  task automatic write_reg(input logic idx, input logic [31:0] value);
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WAYS_IN_USE) cfg_ways_in_use = value[WIU_W-1:0];
    else                        cfg_insert_rrpv = value[INS_W-1:0];
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side ready: random short stalls, rare long ones, steady stretches,
  // and one long hold-off while the sender keeps offering so the block backs up
  // ---------------------------------------------------------------------------
  initial begin : result_ready_gen
    int  r;
    int  hold;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_LEN) @(posedge clk);
      end else if (rx_steady || r < 65) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        hold = (r < 96) ? $urandom_range(1, 4) : $urandom_range(15, 60);
        repeat (hold - 1) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  set_result_t seen_beat;
  set_result_t want_beat;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      seen_beat = '{hit: out_ch.hit, way: out_ch.way_num, evicted: out_ch.evicted,
                    ev_tag: out_ch.evicted_tag};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR result beat with nothing pending: hit=%0b way=%0d ev=%0b ev_tag=%h",
                   seen_beat.hit, seen_beat.way, seen_beat.evicted, seen_beat.ev_tag);
      end else begin
        want_beat = pending_results.pop_front();
        if (seen_beat.hit !== want_beat.hit || seen_beat.way !== want_beat.way ||
            seen_beat.evicted !== want_beat.evicted ||
            seen_beat.ev_tag !== want_beat.ev_tag) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR result %0d: exp hit/way/ev/tag %0b/%0d/%0b/%h, got %0b/%0d/%0b/%h",
                     results_seen, want_beat.hit, want_beat.way, want_beat.evicted,
                     want_beat.ev_tag, seen_beat.hit, seen_beat.way, seen_beat.evicted,
                     seen_beat.ev_tag);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t           directed_rows [$];
    logic [IN_TAG_W-1:0] hot_tags [HOT_TAGS];
    logic [IN_TAG_W-1:0] t;
    logic [IN_TAG_W-1:0] last_tag;
    logic [31:0]         wval;
    logic [31:0]         ival;
    int                  ways_plan [RANDOM_PHASES];
    int                  ins_plan  [RANDOM_PHASES];
    int                  pool_n;
    int                  r;

    // every input known from time zero
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.tag   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;

    // model state after reset
    for (int i = 0; i < WAYS_DEF; i++) begin
      way_valid[i] = 1'b0;
      way_tag[i]   = '0;
      way_rrpv[i]  = '0;
    end
    cfg_ways_in_use = WIU_RESET;
    cfg_insert_rrpv = INS_RESET;

    // Directed part. Typed rows follow by hand from the reset state:
    // fills of empty ways, hits, eviction with two ways in use (RRPV tie goes
    // to way 0, then the inserted RRPV 2 beats the hit way), ways_in_use 0
    // acting as a single way, the tag held in an idle way 1 not hitting,
    // 31 acting as all ways with the duplicate tag hitting the lowest way.
    directed_rows = {directed_rows, typed_row(32'h0000_0000, 1'b0, 4'd0, 1'b0, 32'h0)};
    directed_rows = {directed_rows, typed_row(32'hFFFF_FFFF, 1'b0, 4'd1, 1'b0, 32'h0)};
    directed_rows = {directed_rows, typed_row(32'h0000_0000, 1'b1, 4'd0, 1'b0, 32'h0)};
    directed_rows = {directed_rows, typed_row(32'hFFFF_FFFF, 1'b1, 4'd1, 1'b0, 32'h0)};
    directed_rows = {directed_rows, reg_row(REG_WAYS_IN_USE, 32'd2)};
    directed_rows = {directed_rows, typed_row(32'h5555_AAAA, 1'b0, 4'd0, 1'b1, 32'h0000_0000)};
    directed_rows = {directed_rows, typed_row(32'hAAAA_5555, 1'b0, 4'd0, 1'b1, 32'h5555_AAAA)};
    directed_rows = {directed_rows, reg_row(REG_INSERT_RRPV, 32'hFFFF_FFFF)};
    directed_rows = {directed_rows, reg_row(REG_WAYS_IN_USE, 32'hFFFF_FFE0)};
    directed_rows = {directed_rows, typed_row(32'h0000_0000, 1'b0, 4'd0, 1'b1, 32'hAAAA_5555)};
    directed_rows = {directed_rows, typed_row(32'hFFFF_FFFF, 1'b0, 4'd0, 1'b1, 32'h0000_0000)};
    directed_rows = {directed_rows, reg_row(REG_WAYS_IN_USE, 32'h0000_001F)};
    directed_rows = {directed_rows, reg_row(REG_INSERT_RRPV, 32'h0000_0000)};
    directed_rows = {directed_rows, typed_row(32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0, 32'h0)};
    directed_rows = {directed_rows, typed_row(32'h1234_5678, 1'b0, 4'd2, 1'b0, 32'h0)};
    directed_rows = {directed_rows, reg_row(REG_INSERT_RRPV, 32'd1)};
    directed_rows = {directed_rows, model_row(32'h8000_0000)};
    directed_rows = {directed_rows, model_row(32'h0000_0001)};
    directed_rows = {directed_rows, model_row(32'h1234_5678)};
    directed_rows = {directed_rows, reg_row(REG_WAYS_IN_USE, 32'd17)};
    directed_rows = {directed_rows, model_row(32'h7FFF_FFFF)};
    directed_rows = {directed_rows, model_row(32'hFFFF_FFFE)};

    // per-phase register plan; -1 means a random legal-width value
    ways_plan = '{16, 1, 31, 4, 0, 17, -1, 9};
    ins_plan  = '{2, 3, 0, 1, -1, 3, 0, -1};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        settle_block();
        write_reg(directed_rows[k].reg_idx, directed_rows[k].data);
      end else begin
        pace_sender();
        send_access(directed_rows[k].data, directed_rows[k].kind == ROW_ACCESS_TYPED,
                    directed_rows[k].want);
      end
    end

    // Random part: each phase sets both registers, then mixes hot tags (hits
    // and evictions against a pool a bit larger than the ways in use), repeats
    // of the last tag, and fully random tags.
    for (int i = 0; i < HOT_TAGS; i++) hot_tags[i] = $urandom;
    last_tag = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      wval = (ways_plan[p] < 0) ? 32'($urandom_range(0, 31)) : 32'(ways_plan[p]);
      ival = (ins_plan[p] < 0)  ? 32'($urandom_range(0, 3))  : 32'(ins_plan[p]);
      // junk above the field width must be dropped by the register
      if (p >= 4) begin
        wval = wval | ($urandom << WIU_W);
        ival = ival | ($urandom << INS_W);
      end
      write_reg(REG_WAYS_IN_USE, wval);
      write_reg(REG_INSERT_RRPV, ival);

      tx_steady = (p == 2);
      rx_steady = (p == 2);

      pool_n = active_ways() + $urandom_range(1, 6);
      if (pool_n > HOT_TAGS) pool_n = HOT_TAGS;
      for (int i = 0; i < HOT_TAGS; i++)
        if ($urandom_range(0, 1) == 1) hot_tags[i] = $urandom;

      for (int j = 0; j < PHASE_ACCESSES; j++) begin
        r = $urandom_range(0, 99);
        if (r < 60)      t = hot_tags[$urandom_range(0, pool_n - 1)];
        else if (r < 75) t = last_tag;
        else             t = $urandom;
        last_tag = t;
        pace_sender();
        send_access(t, 1'b0, '0);
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    settle_block();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far past the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[srrip_cache_set_replacement.f]
hw/rtl/srrip_pkg.sv
hw/rtl/srrip_if.sv
hw/rtl/srrip_cell.sv
hw/rtl/srrip_cfg.sv
hw/rtl/srrip_cache_set_replacement.sv
bench/tb_srrip_cache_set_replacement.sv
